// File: src/closest_pose_search_gated_unit_assert.svh
// assertion macros for the closest pose search block
`ifndef CLOSEST_POSE_SEARCH_GATED_UNIT_ASSERT_SVH
`define CLOSEST_POSE_SEARCH_GATED_UNIT_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define CPSG_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("closest pose search check failed");

// condition that must hold in the cycle after the trigger
`define CPSG_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("closest pose search check failed");

`endif

// File: src/cpsg_pkg.sv
// constants and types for the closest pose search block
`default_nettype none

package cpsg_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 24;

  localparam int COUNT_W  = $clog2(MAX_POINTS + 1);
  localparam int INDEX_W  = 12;
  localparam int HEAD_W   = 16;
  localparam int DLIM_W   = 24;
  localparam int HLIM_W   = 16;
  localparam int LIM_SQ_W = 2 * DLIM_W;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int DIST_W   = SQ_W + 1;
  localparam int CMP_W    = (DIST_W > LIM_SQ_W) ? DIST_W : LIM_SQ_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [DLIM_W-1:0] DLIM_RESET = DLIM_W'(20000);
  localparam logic [HLIM_W-1:0] HLIM_RESET = HLIM_W'(16384);

  // register select, taken from address bit 2
  typedef enum logic {
    REG_DISTANCE_LIMIT = 1'b0,
    REG_HEADING_LIMIT  = 1'b1
  } reg_sel_t;

  // item as accepted
  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic [HEAD_W-1:0]            heading;
    logic                         last;
  } stage1_t;

  // after differences and gates
  typedef struct packed {
    logic                  restart;
    logic                  take;
    logic                  last;
    logic [INDEX_W-1:0]    index;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
  } stage2_t;

  // after squares
  typedef struct packed {
    logic               restart;
    logic               take;
    logic               last;
    logic [INDEX_W-1:0] index;
    logic [SQ_W-1:0]    sx;
    logic [SQ_W-1:0]    sy;
  } stage3_t;

endpackage

`default_nettype wire

// File: src/closest_pose_search_gated_unit.sv
// top level of the closest pose search block with distance and heading gates
`default_nettype none

// Nearest path pose search. An item with kind 0 loads the vehicle position and
// heading and opens a new run; each item with kind 1 is one path pose, numbered
// from 0 in the run. A pose counts only if its planar distance is at most
// distance_limit (compared as squares) and its wrapped heading difference is at
// most heading_limit; the nearest such pose wins, ties keep the earlier one. An
// item with last set closes the run and yields one result item (found, index);
// other items yield nothing. Poses past MAX_POINTS in a run are ignored.
// Throughput is one item per clock while no result waits unaccepted at the
// output. The datapath is four register stages: the input register, a stage
// for coordinate and heading differences and the gates, a stage for the two
// squares, and the running-minimum update that also loads the output
// register. The whole pipeline moves together, so input ready drops only
// while a result sits in the output register unaccepted.
// Configuration goes through the APB port: distance_limit at byte address 0,
// heading_limit at byte address 4; the squared limit is refreshed every cycle.
module closest_pose_search_gated_unit (
  input  wire                                     clk,
  input  wire                                     rst,
  // input item channel
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire                                     kind,
  input  wire signed [cpsg_pkg::COORD_BITS-1:0]   pos_x,
  input  wire signed [cpsg_pkg::COORD_BITS-1:0]   pos_y,
  input  wire        [cpsg_pkg::HEAD_W-1:0]       heading,
  input  wire                                     last,
  // result item channel
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic                                    found,
  output logic [cpsg_pkg::INDEX_W-1:0]            best_index,
  // configuration port
  input  wire                                     psel,
  input  wire                                     penable,
  input  wire                                     pwrite,
  input  wire  [cpsg_pkg::APB_AW-1:0]             paddr,
  input  wire  [cpsg_pkg::APB_DW-1:0]             pwdata,
  output logic [cpsg_pkg::APB_DW-1:0]             prdata,
  output logic                                    pready
);

  localparam int C = cpsg_pkg::COORD_BITS;

  // configuration registers
  logic [cpsg_pkg::DLIM_W-1:0]   distance_limit;
  logic [cpsg_pkg::HLIM_W-1:0]   heading_limit;
  logic [cpsg_pkg::LIM_SQ_W-1:0] lim_sq;

  // search state
  logic signed [C-1:0]          vehicle_x;
  logic signed [C-1:0]          vehicle_y;
  logic [cpsg_pkg::HEAD_W-1:0]  vehicle_heading;
  logic [cpsg_pkg::COUNT_W-1:0] pose_count;
  logic [cpsg_pkg::COUNT_W-1:0] pose_count_next;
  logic                         have_best;
  logic [cpsg_pkg::DIST_W-1:0]  best_dist;
  logic [cpsg_pkg::INDEX_W-1:0] best_pos;

  // pipeline
  logic              adv;
  logic              v1, v2, v3;
  cpsg_pkg::stage1_t s1;
  cpsg_pkg::stage2_t s2, s2_next;
  cpsg_pkg::stage3_t s3, s3_next;

  // stage 1 datapath
  logic [C:0]                  diff_x, diff_y;
  logic [C:0]                  mag_x, mag_y;
  logic [cpsg_pkg::HEAD_W-1:0] head_diff, head_mag;
  logic                        room, head_ok;

  // stage 3 datapath
  logic [cpsg_pkg::DIST_W-1:0] dist_sq;
  logic                        pass, better, replace, found_next;
  logic [cpsg_pkg::INDEX_W-1:0] pos_next;

  logic cfg_write;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= cpsg_pkg::DLIM_RESET;
      heading_limit  <= cpsg_pkg::HLIM_RESET;
    end else if (cfg_write) begin
      case (cpsg_pkg::reg_sel_t'(paddr[2]))
        cpsg_pkg::REG_DISTANCE_LIMIT: distance_limit <= pwdata[cpsg_pkg::DLIM_W-1:0];
        cpsg_pkg::REG_HEADING_LIMIT:  heading_limit  <= pwdata[cpsg_pkg::HLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cpsg_pkg::reg_sel_t'(paddr[2]))
      cpsg_pkg::REG_DISTANCE_LIMIT: prdata = cpsg_pkg::APB_DW'(distance_limit);
      cpsg_pkg::REG_HEADING_LIMIT:  prdata = cpsg_pkg::APB_DW'(heading_limit);
      default:                      prdata = '0;
    endcase
  end

  // squared limit, registered from distance_limit
  always_ff @(posedge clk) begin
    lim_sq <= cpsg_pkg::LIM_SQ_W'(distance_limit) * cpsg_pkg::LIM_SQ_W'(distance_limit);
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: everything moves unless a result waits unaccepted at the output
  // ---------------------------------------------------------------------------
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1.kind    <= kind;
      s1.pos_x   <= pos_x;
      s1.pos_y   <= pos_y;
      s1.heading <= heading;
      s1.last    <= last;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 -> 2: differences, heading gate, pose numbering
  // ---------------------------------------------------------------------------
  always_comb begin
    diff_x    = {s1.pos_x[C-1], s1.pos_x} - {vehicle_x[C-1], vehicle_x};
    diff_y    = {s1.pos_y[C-1], s1.pos_y} - {vehicle_y[C-1], vehicle_y};
    mag_x     = diff_x[C] ? (~diff_x + 1'b1) : diff_x;
    mag_y     = diff_y[C] ? (~diff_y + 1'b1) : diff_y;
    // binary angles wrap for free; the most negative difference maps to pi
    head_diff = vehicle_heading - s1.heading;
    head_mag  = head_diff[cpsg_pkg::HEAD_W-1] ? (~head_diff + 1'b1) : head_diff;
    head_ok   = head_mag <= heading_limit;
    room      = pose_count < cpsg_pkg::COUNT_W'(cpsg_pkg::MAX_POINTS);

    s2_next.restart = !s1.kind;
    s2_next.take    = s1.kind && room && head_ok;
    s2_next.last    = s1.last;
    s2_next.index   = cpsg_pkg::INDEX_W'(pose_count);
    s2_next.dx      = mag_x[C-1:0];
    s2_next.dy      = mag_y[C-1:0];

    // count restarts on a vehicle item or at the close of a run
    if (!s1.kind || s1.last) begin
      pose_count_next = '0;
    end else if (room) begin
      pose_count_next = pose_count + 1'b1;
    end else begin
      pose_count_next = pose_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_x       <= '0;
      vehicle_y       <= '0;
      vehicle_heading <= '0;
      pose_count      <= '0;
    end else if (adv && v1) begin
      pose_count <= pose_count_next;
      if (!s1.kind) begin
        vehicle_x       <= s1.pos_x;
        vehicle_y       <= s1.pos_y;
        vehicle_heading <= s1.heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2 -> 3: squares
  // ---------------------------------------------------------------------------
  always_comb begin
    s3_next.restart = s2.restart;
    s3_next.take    = s2.take;
    s3_next.last    = s2.last;
    s3_next.index   = s2.index;
    s3_next.sx      = cpsg_pkg::SQ_W'(s2.dx) * cpsg_pkg::SQ_W'(s2.dx);
    s3_next.sy      = cpsg_pkg::SQ_W'(s2.dy) * cpsg_pkg::SQ_W'(s2.dy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3 <= s3_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: distance gate, running minimum, result
  // ---------------------------------------------------------------------------
  always_comb begin
    dist_sq = cpsg_pkg::DIST_W'(s3.sx) + cpsg_pkg::DIST_W'(s3.sy);
    pass    = s3.take && (cpsg_pkg::CMP_W'(dist_sq) <= cpsg_pkg::CMP_W'(lim_sq));
    // strict compare keeps the first pose on a tie
    better  = !have_best || (dist_sq < best_dist);
    replace = pass && better;
    found_next = !s3.restart && (have_best || replace);
    pos_next   = replace ? s3.index : best_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (adv && v3) begin
      if (s3.restart || s3.last) begin
        have_best <= 1'b0;
      end else if (replace) begin
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3 && replace) begin
      best_dist <= dist_sq;
      best_pos  <= s3.index;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3 && s3.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3 && s3.last) begin
      found      <= found_next;
      best_index <= found_next ? pos_next : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`include "closest_pose_search_gated_unit_assert.svh"

  `CPSG_CHECK(a_index_zero_when_none, !out_valid || found || (best_index == '0))
  `CPSG_CHECK(a_count_bounded, pose_count <= cpsg_pkg::COUNT_W'(cpsg_pkg::MAX_POINTS))
  `CPSG_CHECK_NEXT(a_close_clears_best, adv && v3 && s3.last, !have_best)

endmodule

`default_nettype wire
